// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the rasterizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== hdl/mcr_pkg.sv =====
// Types and constants of the midpoint circle rasterizer.
package mcr_pkg;

  localparam logic       ACT_START  = 1'b0;
  localparam logic       ACT_STEP   = 1'b1;
  localparam logic [7:0] MAX_RADIUS = 8'd255;
  localparam logic [2:0] LAST_PIXEL = 3'd7;

  typedef struct packed {
    logic        action;
    logic [7:0]  center_x;
    logic [8:0]  center_y;
    logic [7:0]  radius;
    logic [15:0] color;
    logic        fill;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [15:0] pixel_color;
    logic        last_of_step;
    logic        figure_done;
  } out_item_t;

  // Snapshot of one step: offsets and figure data for its eight pixels.
  typedef struct packed {
    logic [8:0]  off_x;
    logic [8:0]  off_y;
    logic [7:0]  center_x;
    logic [8:0]  center_y;
    logic [15:0] color;
    logic        figure_end;
  } job_t;

endpackage

// ===== hdl/midpoint_circle_rasterizer.sv =====
// Midpoint circle rasterizer top level: state update, step sequencer, output register.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  in       | in_valid/in_stall  | in_item  (action, center, radius, color, fill)
//  out      | out_valid/out_stall| out_item (pixel x/y, color, step/figure flags)
//
// A start item or an idle step emits nothing.
// A busy step emits eight pixels, one per cycle while out_stall stays low.
// The next step is taken in the cycle its predecessor's eighth pixel is issued.
// Reset clears all control and circle state; out_stall freezes the output
// register and the pixel sequencer.
module midpoint_circle_rasterizer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mcr_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output mcr_pkg::out_item_t out_item
);
  import mcr_pkg::*;
  `include "assert_macros.svh"

  // circle state
  logic        busy_r, busy_nxt;
  logic [8:0]  x_r, x_nxt, y_r, y_nxt;
  logic [11:0] dec_r, dec_nxt;
  logic [7:0]  rad_r, rad_nxt;
  logic [7:0]  cx_r, cx_nxt;
  logic [8:0]  cy_r, cy_nxt;
  logic [15:0] color_r, color_nxt;
  logic        fill_r, fill_nxt;

  // pixel sequencer
  logic        job_valid_r, job_valid_nxt;
  logic [2:0]  job_k_r, job_k_nxt;
  job_t        job_r, job_nxt;

  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r, out_item_nxt, pix;

  logic        out_load, emit, job_last, in_fire, step_fire;
  logic        dec_neg, y_under, circle_end, figure_end;
  logic [8:0]  nx, ny;
  logic [11:0] nd, x12, y12, diff12;
  logic [7:0]  rad_in, rad_m1;

  assign out_load  = !out_valid_r || !out_stall;
  assign emit      = job_valid_r && out_load;
  assign job_last  = (job_k_r == LAST_PIXEL);
  assign in_stall  = job_valid_r && !(emit && job_last);
  assign in_fire   = in_valid && !in_stall;
  assign step_fire = in_fire && (in_item.action == ACT_STEP) && busy_r;

  // midpoint decision update
  always_comb begin
    x12     = {3'b0, x_r};
    y12     = {3'b0, y_r};
    diff12  = x12 - y12;
    dec_neg = dec_r[11];
    nx      = x_r + 9'd1;
    if (dec_neg) begin
      nd = dec_r + {x12[9:0], 2'b00} + 12'd6;
      ny = y_r;
    end else begin
      nd = dec_r + {diff12[9:0], 2'b00} + 12'd10;
      ny = y_r - 9'd1;
    end
    y_under    = !dec_neg && (y_r == 9'd0);
    circle_end = y_under || (nx > ny);
    figure_end = circle_end && !(fill_r && (rad_r > 8'd1));
    rad_in     = (in_item.radius > MAX_RADIUS) ? MAX_RADIUS : in_item.radius;
    rad_m1     = rad_r - 8'd1;
  end

  always_comb begin
    busy_nxt  = busy_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    dec_nxt   = dec_r;
    rad_nxt   = rad_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    color_nxt = color_r;
    fill_nxt  = fill_r;
    if (in_fire && (in_item.action == ACT_START)) begin
      cx_nxt    = in_item.center_x;
      cy_nxt    = in_item.center_y;
      color_nxt = in_item.color;
      fill_nxt  = in_item.fill;
      rad_nxt   = rad_in;
      x_nxt     = 9'd0;
      y_nxt     = {1'b0, rad_in};
      dec_nxt   = 12'd3 - {3'b0, rad_in, 1'b0};
      busy_nxt  = !(in_item.fill && (rad_in == 8'd0));
    end else if (step_fire) begin
      if (figure_end) begin
        busy_nxt = 1'b0;
        x_nxt    = nx;
        y_nxt    = y_under ? 9'd0 : ny;
        dec_nxt  = nd;
      end else if (circle_end) begin
        // restart one pixel further in
        rad_nxt = rad_m1;
        x_nxt   = 9'd0;
        y_nxt   = {1'b0, rad_m1};
        dec_nxt = 12'd3 - {3'b0, rad_m1, 1'b0};
      end else begin
        x_nxt   = nx;
        y_nxt   = ny;
        dec_nxt = nd;
      end
    end
  end

  always_comb begin
    job_valid_nxt = job_valid_r;
    job_k_nxt     = job_k_r;
    job_nxt       = job_r;
    if (step_fire) begin
      job_valid_nxt      = 1'b1;
      job_k_nxt          = 3'd0;
      job_nxt.off_x      = x_r;
      job_nxt.off_y      = y_r;
      job_nxt.center_x   = cx_r;
      job_nxt.center_y   = cy_r;
      job_nxt.color      = color_r;
      job_nxt.figure_end = figure_end;
    end else if (emit) begin
      job_valid_nxt = !job_last;
      job_k_nxt     = job_k_r + 3'd1;
    end
  end

  mcr_octant u_octant (
    .job (job_r),
    .idx (job_k_r),
    .pix (pix)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (out_load) begin
      out_valid_nxt = emit;
      out_item_nxt  = pix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      x_r         <= 9'd0;
      y_r         <= 9'd0;
      dec_r       <= 12'd0;
      rad_r       <= 8'd0;
      cx_r        <= 8'd0;
      cy_r        <= 9'd0;
      color_r     <= 16'd0;
      fill_r      <= 1'b0;
      job_valid_r <= 1'b0;
      job_k_r     <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      dec_r       <= dec_nxt;
      rad_r       <= rad_nxt;
      cx_r        <= cx_nxt;
      cy_r        <= cy_nxt;
      color_r     <= color_nxt;
      fill_r      <= fill_nxt;
      job_valid_r <= job_valid_nxt;
      job_k_r     <= job_k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `ASSERT_NEXT(a_job_continues, clk, rst_n, emit && !job_last && !step_fire, job_valid_r)
  `ASSERT_IMPLIES(a_done_on_last, clk, rst_n, out_valid_r && out_item_r.figure_done, out_item_r.last_of_step)
  `ASSERT_NEXT(a_idle_after_figure, clk, rst_n, step_fire && figure_end, !busy_r)
  `ASSERT_NEXT(a_last_pixel_ends_job, clk, rst_n, emit && job_last && !step_fire, !job_valid_r)

endmodule

// ===== hdl/mcr_octant.sv =====
// Octant mirror: forms one of the eight symmetric pixels of a step.
module mcr_octant (
  input  mcr_pkg::job_t     job,
  input  logic [2:0]        idx,
  output mcr_pkg::out_item_t pix
);
  import mcr_pkg::*;

  logic [15:0] ox, oy, dx, dy, cx, cy;

  always_comb begin
    ox = {7'b0, job.off_x};
    oy = {7'b0, job.off_y};
    cx = {8'b0, job.center_x};
    cy = {7'b0, job.center_y};
    // bit 2 swaps the axes, bit 1 negates the column, bit 0 the row
    dx = idx[2] ? oy : ox;
    dy = idx[2] ? ox : oy;
    pix.pixel_x      = idx[1] ? cx - dx : cx + dx;
    pix.pixel_y      = idx[0] ? cy - dy : cy + dy;
    pix.pixel_color  = job.color;
    pix.last_of_step = (idx == LAST_PIXEL);
    pix.figure_done  = (idx == LAST_PIXEL) && job.figure_end;
  end

endmodule
